[design/dspv_pkg.sv]
// ----------------------------------------------------------------------------
// Doppler spectrum peak velocity package
// Shared widths, register indexes and pipeline context types.
// ----------------------------------------------------------------------------
package dspv_pkg;

    localparam int MaxPoints    = 1024;
    localparam int MaxRangeBins = 64;
    localparam int BinW         = $clog2(MaxPoints);
    localparam int RowW         = $clog2(MaxRangeBins + 2) + 1;
    localparam int NpW          = 11;
    localparam int NrbW         = 7;
    localparam int HwW          = 10;
    localparam int StepW        = 32;
    localparam int PowW         = 48;
    localparam int DiffW        = PowW + 1;
    localparam int VelW         = 43;
    localparam int OfsW         = 11;
    localparam int RbW          = 6;
    localparam int CfgIdxW      = 2;
    localparam int CfgDataW     = 32;

    // configuration register indexes
    typedef enum logic [CfgIdxW-1:0] {
        CFG_NUM_POINTS     = 2'd0,
        CFG_NUM_RANGE_BINS = 2'd1,
        CFG_HALF_WINDOW    = 2'd2,
        CFG_VELOCITY_STEP  = 2'd3
    } t_cfg_idx;

    // context of a bin between memory read and compare
    typedef struct packed {
        logic            is_ref;
        logic            is_rng;
        logic            eor;
        logic            last;
        logic [RbW-1:0]  rbin;
        logic [BinW-1:0] bin;
        logic [PowW-1:0] power;
    } t_s1_ctx;

    // context of a finished range row before the velocity multiply
    typedef struct packed {
        logic [BinW-1:0] peak;
        logic [BinW-1:0] refi;
        logic            last;
        logic [RbW-1:0]  rbin;
    } t_s2_ctx;

endpackage

[design/dspv_in_if.sv]
// ----------------------------------------------------------------------------
// Spectrum bin stream interface
// Valid/ready channel carrying one power bin per transaction.
// ----------------------------------------------------------------------------
interface dspv_in_if;
    logic                       valid;
    logic                       ready;
    logic [dspv_pkg::PowW-1:0]  power;

    modport source (output valid, output power, input ready);
    modport sink   (input valid, input power, output ready);
endinterface

[design/dspv_out_if.sv]
// ----------------------------------------------------------------------------
// Velocity result stream interface
// Valid/ready channel carrying one range-row velocity per transaction.
// ----------------------------------------------------------------------------
interface dspv_out_if;
    logic                             valid;
    logic                             ready;
    logic signed [dspv_pkg::VelW-1:0] velocity;
    logic [dspv_pkg::RbW-1:0]         range_bin;
    logic signed [dspv_pkg::OfsW-1:0] peak_offset;
    logic                             last_bin;

    modport source (output valid, output velocity, output range_bin,
                    output peak_offset, output last_bin, input ready);
    modport sink   (input valid, input velocity, input range_bin,
                    input peak_offset, input last_bin, output ready);
endinterface

[design/doppler_spectrum_peak_velocity.sv]
// ----------------------------------------------------------------------------
// Doppler spectrum peak velocity
// Background subtraction, reference and windowed peak search, velocity out.
// ----------------------------------------------------------------------------
// Throughput: one bin per cycle; the background memory sees one address per
//   bin (row 0 writes it, later rows read it). Input stalls only while a
//   finished range row waits behind an output transaction not yet taken.
// Result path: the last bin of a range row passes the stage 1 register
//   (memory read), stage 2 register (compare) and output reg (multiply).
// Reset: counters, reference and row search cleared, registers to defaults;
//   background memory is not cleared (row 0 of each capture writes it).
module doppler_spectrum_peak_velocity (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    dspv_in_if.sink                            i_in,
    dspv_out_if.source                         o_out,
    input  logic                               i_cfg_we,
    input  logic [dspv_pkg::CfgIdxW-1:0]       i_cfg_idx,
    input  logic [dspv_pkg::CfgDataW-1:0]      i_cfg_data
);

    // ---------------- configuration registers
    logic [dspv_pkg::NpW-1:0]   r_np;
    logic [dspv_pkg::NrbW-1:0]  r_nrb;
    logic [dspv_pkg::HwW-1:0]   r_hw;
    logic [dspv_pkg::StepW-1:0] r_step;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_np   <= dspv_pkg::NpW'(512);
            r_nrb  <= dspv_pkg::NrbW'(32);
            r_hw   <= dspv_pkg::HwW'(20);
            r_step <= dspv_pkg::StepW'(65536);
        end else if (i_cfg_we) begin
            unique case (dspv_pkg::t_cfg_idx'(i_cfg_idx))
                dspv_pkg::CFG_NUM_POINTS:     r_np   <= i_cfg_data[dspv_pkg::NpW-1:0];
                dspv_pkg::CFG_NUM_RANGE_BINS: r_nrb  <= i_cfg_data[dspv_pkg::NrbW-1:0];
                dspv_pkg::CFG_HALF_WINDOW:    r_hw   <= i_cfg_data[dspv_pkg::HwW-1:0];
                dspv_pkg::CFG_VELOCITY_STEP:  r_step <= i_cfg_data[dspv_pkg::StepW-1:0];
                default: ;
            endcase
        end
    end

    // saturated bin and row counts
    logic [dspv_pkg::NpW-1:0]  np_eff;
    logic [dspv_pkg::BinW-1:0] np_m1;
    logic [dspv_pkg::NrbW-1:0] nrb_eff;

    always_comb begin
        if (r_np < dspv_pkg::NpW'(2))                       np_eff = dspv_pkg::NpW'(2);
        else if (r_np > dspv_pkg::NpW'(dspv_pkg::MaxPoints)) np_eff = dspv_pkg::NpW'(dspv_pkg::MaxPoints);
        else                                                np_eff = r_np;
        if (r_nrb < dspv_pkg::NrbW'(1))                          nrb_eff = dspv_pkg::NrbW'(1);
        else if (r_nrb > dspv_pkg::NrbW'(dspv_pkg::MaxRangeBins)) nrb_eff = dspv_pkg::NrbW'(dspv_pkg::MaxRangeBins);
        else                                                     nrb_eff = r_nrb;
    end

    assign np_m1 = dspv_pkg::BinW'(np_eff - dspv_pkg::NpW'(1));

    // ---------------- pipeline control
    logic                  r_s1_vld;
    dspv_pkg::t_s1_ctx     r_s1;
    logic                  r_s2_res;
    dspv_pkg::t_s2_ctx     r_s2;
    logic                  r_out_vld;
    logic                  en;
    logic                  acc;

    // all stages hold only when a result waits behind a full output register
    assign en         = !(r_out_vld && r_s2_res);
    assign i_in.ready = en;
    assign acc        = i_in.valid && en;

    // ---------------- stage 0: bin/row counters, memory access
    logic [dspv_pkg::BinW-1:0] r_bin;
    logic [dspv_pkg::RowW-1:0] r_row;
    logic                      s0_eor;
    logic                      s0_last;
    logic [dspv_pkg::RowW-1:0] row_m1;

    assign s0_eor  = (r_bin >= np_m1);
    assign row_m1  = r_row - dspv_pkg::RowW'(1);
    assign s0_last = (r_row >= dspv_pkg::RowW'(2)) &&
                     (row_m1 >= dspv_pkg::RowW'(nrb_eff));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_bin <= '0;
            r_row <= '0;
        end else if (acc) begin
            if (s0_eor) begin
                r_bin <= '0;
                if (s0_last) r_row <= '0;
                else         r_row <= r_row + dspv_pkg::RowW'(1);
            end else begin
                r_bin <= r_bin + dspv_pkg::BinW'(1);
            end
        end
    end

    // background spectrum memory
    logic [dspv_pkg::PowW-1:0] r_bg_mem [dspv_pkg::MaxPoints];
    logic [dspv_pkg::PowW-1:0] r_bg;

    always_ff @(posedge i_clk) begin
        if (acc && (r_row == '0)) r_bg_mem[r_bin] <= i_in.power;
        if (en) r_bg <= r_bg_mem[r_bin];
    end

    // stage 1 context
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_vld <= 1'b0;
        end else if (en) begin
            r_s1_vld <= i_in.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_s1.is_ref <= (r_row == dspv_pkg::RowW'(1));
            r_s1.is_rng <= (r_row >= dspv_pkg::RowW'(2));
            r_s1.eor    <= s0_eor;
            r_s1.last   <= s0_last;
            r_s1.rbin   <= dspv_pkg::RbW'(r_row - dspv_pkg::RowW'(2));
            r_s1.bin    <= r_bin;
            r_s1.power  <= i_in.power;
        end
    end

    // ---------------- stage 1: subtract, window, compare
    logic [dspv_pkg::BinW-1:0]         r_ref_idx;
    logic signed [dspv_pkg::DiffW-1:0] r_ref_best;
    logic signed [dspv_pkg::DiffW-1:0] r_best_val;
    logic [dspv_pkg::BinW-1:0]         r_best_idx;
    logic                              r_best_vld;

    logic signed [dspv_pkg::DiffW-1:0] diff;
    logic [dspv_pkg::BinW-1:0]         refc;
    logic [dspv_pkg::BinW-1:0]         lo;
    logic [dspv_pkg::BinW-1:0]         hi;
    logic [dspv_pkg::BinW:0]           hi_sum;
    logic                              in_win;
    logic                              ref_upd;
    logic                              rng_upd;
    logic                              row_done;
    logic                              best_vld_a;
    logic [dspv_pkg::BinW-1:0]         best_idx_a;
    logic [dspv_pkg::BinW-1:0]         peak;

    assign diff = $signed({1'b0, r_s1.power}) - $signed({1'b0, r_bg});

    // window around the reference, clamped to the spectrum in use
    always_comb begin
        refc   = (r_ref_idx > np_m1) ? np_m1 : r_ref_idx;
        lo     = (refc > r_hw) ? refc - r_hw : '0;
        hi_sum = {1'b0, refc} + {1'b0, r_hw};
        hi     = (hi_sum > {1'b0, np_m1}) ? np_m1 : hi_sum[dspv_pkg::BinW-1:0];
        in_win = (r_s1.bin >= lo) && (r_s1.bin <= hi);
    end

    assign ref_upd  = r_s1_vld && r_s1.is_ref &&
                      ((r_s1.bin == '0) || (diff > r_ref_best));
    assign rng_upd  = r_s1_vld && r_s1.is_rng && in_win &&
                      (!r_best_vld || (diff > r_best_val));
    assign row_done = r_s1_vld && r_s1.is_rng && r_s1.eor;

    // peak including this bin; reference when no window bin was seen
    assign best_vld_a = r_best_vld || rng_upd;
    assign best_idx_a = rng_upd ? r_s1.bin : r_best_idx;
    assign peak       = best_vld_a ? best_idx_a : refc;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ref_idx  <= '0;
            r_ref_best <= '0;
            r_best_val <= '0;
            r_best_idx <= '0;
            r_best_vld <= 1'b0;
        end else if (en) begin
            if (ref_upd) begin
                r_ref_idx  <= r_s1.bin;
                r_ref_best <= diff;
            end
            if (row_done) begin
                r_best_val <= '0;
                r_best_idx <= '0;
                r_best_vld <= 1'b0;
            end else if (rng_upd) begin
                r_best_val <= diff;
                r_best_idx <= r_s1.bin;
                r_best_vld <= 1'b1;
            end
        end
    end

    // stage 2 context
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s2_res <= 1'b0;
        end else if (en) begin
            r_s2_res <= row_done;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_s2.peak <= peak;
            r_s2.refi <= refc;
            r_s2.last <= r_s1.last;
            r_s2.rbin <= r_s1.rbin;
        end
    end

    // ---------------- stage 2: velocity = (ref - peak) * step
    logic signed [dspv_pkg::OfsW-1:0]  ofs_neg;
    logic signed [dspv_pkg::OfsW-1:0]  ofs;
    logic signed [dspv_pkg::StepW:0]   step_s;
    logic signed [dspv_pkg::OfsW+dspv_pkg::StepW:0] prod;

    assign ofs_neg = $signed({1'b0, r_s2.refi}) - $signed({1'b0, r_s2.peak});
    assign ofs     = $signed({1'b0, r_s2.peak}) - $signed({1'b0, r_s2.refi});
    assign step_s  = $signed({1'b0, r_step});
    assign prod    = (dspv_pkg::OfsW + dspv_pkg::StepW + 1)'(ofs_neg) *
                     (dspv_pkg::OfsW + dspv_pkg::StepW + 1)'(step_s);

    // ---------------- output register
    logic signed [dspv_pkg::VelW-1:0] r_vel;
    logic [dspv_pkg::RbW-1:0]         r_rbin;
    logic signed [dspv_pkg::OfsW-1:0] r_ofs;
    logic                             r_last;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else if (en && r_s2_res) begin
            r_out_vld <= 1'b1;
        end else if (o_out.ready) begin
            r_out_vld <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en && r_s2_res) begin
            r_vel  <= prod[dspv_pkg::VelW-1:0];
            r_rbin <= r_s2.rbin;
            r_ofs  <= ofs;
            r_last <= r_s2.last;
        end
    end

    assign o_out.valid       = r_out_vld;
    assign o_out.velocity    = r_vel;
    assign o_out.range_bin   = r_rbin;
    assign o_out.peak_offset = r_ofs;
    assign o_out.last_bin    = r_last;

    // ---------------- assertions
    a_bin_wrap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (acc && s0_eor) |=> (r_bin == '0))
        else $error("bin counter did not wrap at end of row");

    a_capture_restart: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (acc && s0_eor && s0_last) |=> (r_row == '0))
        else $error("capture did not restart after final range row");

    a_row_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_row <= dspv_pkg::RowW'(dspv_pkg::MaxRangeBins + 1))
        else $error("row counter out of range");

    a_result_cleared: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (en && row_done) |=> !r_best_vld)
        else $error("row search not cleared after result");

endmodule

[dv/doppler_spectrum_peak_velocity_tb.sv]
// ----------------------------------------------------------------------------
// Doppler spectrum peak velocity testbench
// Streams background, reference and range rows of power bins through the
// block under random source and sink idling, predicts every range-row
// velocity with a cycle-free model kept in a scoreboard, and compares each
// velocity transaction as a whole record in arrival order.
// ----------------------------------------------------------------------------
module doppler_spectrum_peak_velocity_tb;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int              MaxPoints     = dspv_pkg::MaxPoints;
    localparam int              MaxRangeBins  = dspv_pkg::MaxRangeBins;
    localparam int              NpW           = dspv_pkg::NpW;
    localparam int              NrbW          = dspv_pkg::NrbW;
    localparam int              HwW           = dspv_pkg::HwW;
    localparam int              StepW         = dspv_pkg::StepW;
    localparam int              PowW          = dspv_pkg::PowW;
    localparam int              VelW          = dspv_pkg::VelW;
    localparam int              OfsW          = dspv_pkg::OfsW;
    localparam int              RbW           = dspv_pkg::RbW;
    localparam int              CfgIdxW       = dspv_pkg::CfgIdxW;
    localparam int              CfgDataW      = dspv_pkg::CfgDataW;

    localparam int              WatchdogLimit = 4000;
    localparam int              SettleCycles  = 8;
    localparam int              RandomItems   = 300;
    localparam int              WideNp        = 32;
    localparam logic [PowW-1:0] PowMax        = {PowW{1'b1}};
    localparam longint          VelHi         = 64'sd4398046511103;
    localparam longint          VelLo         = -64'sd4398046511104;
    localparam longint          OfsLim        = 1023;

    // one expected or observed velocity transaction
    typedef struct packed {
        logic signed [VelW-1:0] velocity;
        logic [RbW-1:0]         range_bin;
        logic signed [OfsW-1:0] peak_offset;
        logic                   last_bin;
    } t_velocity_rec;

    // content style of one generated row
    typedef enum int {
        ROW_RANDOM,
        ROW_SPIKE,
        ROW_FLAT,
        ROW_SMALL,
        ROW_EXTREME
    } t_row_mode;

    // ------------------------------------------------------------------------
    // Scoreboard: spectrum peak predictor plus queue of pending velocities
    // ------------------------------------------------------------------------
    class t_velocity_scoreboard;
        bit [PowW-1:0]  bg_mem  [MaxPoints];
        bit             bg_seen [MaxPoints];
        int unsigned    bin_cnt;
        int unsigned    row_cnt;
        int unsigned    ref_idx;
        int unsigned    best_idx;
        longint         ref_best;
        longint         best_val;
        bit             best_ok;
        bit [NpW-1:0]   np_reg;
        bit [NrbW-1:0]  nrb_reg;
        bit [HwW-1:0]   hw_reg;
        bit [StepW-1:0] step_reg;
        t_velocity_rec  pending_velocities [$];
        int             errors;
        int             checked;

        function new();
            np_reg   = 11'd512;
            nrb_reg  = 7'd32;
            hw_reg   = 10'd20;
            step_reg = 32'd65536;
        endfunction

        function int unsigned eff_np();
            if (np_reg < 2) return 2;
            if (np_reg > MaxPoints) return MaxPoints;
            return np_reg;
        endfunction

        function int unsigned eff_nrb();
            if (nrb_reg < 1) return 1;
            if (nrb_reg > MaxRangeBins) return MaxRangeBins;
            return nrb_reg;
        endfunction

        function int pending();
            return pending_velocities.size();
        endfunction

        function void write_cfg(dspv_pkg::t_cfg_idx idx, logic [CfgDataW-1:0] data);
            case (idx)
                dspv_pkg::CFG_NUM_POINTS:     np_reg   = data[NpW-1:0];
                dspv_pkg::CFG_NUM_RANGE_BINS: nrb_reg  = data[NrbW-1:0];
                dspv_pkg::CFG_HALF_WINDOW:    hw_reg   = data[HwW-1:0];
                dspv_pkg::CFG_VELOCITY_STEP:  step_reg = data[StepW-1:0];
                default: ;
            endcase
        endfunction

        // advance the peak search by one accepted bin
        function void absorb_bin(logic [PowW-1:0] pw);
            int unsigned   np;
            int unsigned   nrb;
            int unsigned   hw;
            int unsigned   bin;
            int unsigned   rf;
            int unsigned   lo;
            int unsigned   hi;
            longint        diff;
            longint        peak;
            longint        ofs;
            longint        vel;
            longint        ofs_out;
            bit            last;
            t_velocity_rec rec;
            np  = eff_np();
            nrb = eff_nrb();
            hw  = hw_reg;
            bin = bin_cnt % MaxPoints;
            // reference clamped to the spectrum when num_points shrank
            rf  = (ref_idx > np - 1) ? np - 1 : ref_idx;
            lo  = (rf > hw) ? rf - hw : 0;
            hi  = (rf + hw > np - 1) ? np - 1 : rf + hw;
            diff = longint'(pw) - longint'(bg_mem[bin]);

            if (row_cnt == 0) begin
                bg_mem[bin]  = pw;
                bg_seen[bin] = 1'b1;
            end else if (row_cnt == 1) begin
                if (bin == 0 || diff > ref_best) begin
                    ref_best = diff;
                    ref_idx  = bin;
                end
            end else if (bin >= lo && bin <= hi) begin
                // strict compare keeps the lowest bin on ties
                if (!best_ok || diff > best_val) begin
                    best_val = diff;
                    best_idx = bin;
                    best_ok  = 1'b1;
                end
            end

            if (bin + 1 >= np) begin
                bin_cnt = 0;
                if (row_cnt >= 2) begin
                    peak    = best_ok ? longint'(best_idx) : longint'(rf);
                    ofs     = peak - longint'(rf);
                    vel     = -ofs * longint'(step_reg);
                    ofs_out = ofs;
                    last    = (row_cnt - 1 >= nrb);
                    if (vel > VelHi) vel = VelHi;
                    if (vel < VelLo) vel = VelLo;
                    if (ofs_out > OfsLim) ofs_out = OfsLim;
                    if (ofs_out < -OfsLim) ofs_out = -OfsLim;
                    rec.velocity    = vel[VelW-1:0];
                    rec.range_bin   = RbW'(row_cnt - 2);
                    rec.peak_offset = ofs_out[OfsW-1:0];
                    rec.last_bin    = last;
                    pending_velocities.push_back(rec);
                    best_ok  = 1'b0;
                    best_val = 0;
                    best_idx = 0;
                    if (last) row_cnt = 0;
                    else row_cnt++;
                end else begin
                    row_cnt++;
                end
            end else begin
                bin_cnt = bin + 1;
            end
        endfunction

        // compare one velocity transaction with the oldest prediction
        function void check_velocity(t_velocity_rec got);
            t_velocity_rec want;
            checked++;
            if (pending_velocities.size() == 0) begin
                errors++;
                if (errors <= 10)
                    $display("unexpected velocity: vel=%0d rb=%0d ofs=%0d last=%0b",
                             got.velocity, got.range_bin, got.peak_offset, got.last_bin);
            end else begin
                want = pending_velocities.pop_front();
                if (want !== got) begin
                    errors++;
                    // fields: velocity/range_bin/peak_offset/last_bin
                    if (errors <= 10)
                        $display("velocity mismatch: exp %0d/%0d/%0d/%0b got %0d/%0d/%0d/%0b",
                                 want.velocity, want.range_bin, want.peak_offset,
                                 want.last_bin, got.velocity, got.range_bin,
                                 got.peak_offset, got.last_bin);
                end
            end
        endfunction
    endclass

    // ------------------------------------------------------------------------
    // Clock, reset, channels and block instance
    // ------------------------------------------------------------------------
    logic                i_clk = 1'b0;
    logic                i_rst_n;
    logic                cfg_we;
    logic [CfgIdxW-1:0]  cfg_idx;
    logic [CfgDataW-1:0] cfg_data;

    dspv_in_if  bins_if ();
    dspv_out_if vel_if ();

    doppler_spectrum_peak_velocity u_top (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in       (bins_if),
        .o_out      (vel_if),
        .i_cfg_we   (cfg_we),
        .i_cfg_idx  (cfg_idx),
        .i_cfg_data (cfg_data)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    t_velocity_scoreboard sb;

    // stimulus shaping state
    bit              calm;
    t_row_mode       row_mode;
    int              spike_bin;
    logic [PowW-1:0] flat_level;
    int              force_ref = -1;
    int              force_rng = -1;
    int              idle_cycles;

    // mostly short gaps, a few long ones, none in calm stretches
    function automatic int unsigned pick_gap();
        int unsigned r;
        r = $urandom_range(0, 99);
        if (calm) return 0;
        if (r < 55) return 0;
        if (r < 85) return $urandom_range(1, 3);
        if (r < 97) return $urandom_range(4, 10);
        return $urandom_range(20, 60);
    endfunction

    function automatic logic [PowW-1:0] rand_power();
        logic [63:0] w;
        w = {$urandom, $urandom};
        return w[PowW-1:0];
    endfunction

    // spike position: spectrum edges, window edges and just outside them
    function automatic int pick_spike();
        int np_e;
        int rf;
        int hw;
        int s;
        np_e = sb.eff_np();
        rf   = (sb.ref_idx > np_e - 1) ? np_e - 1 : sb.ref_idx;
        hw   = sb.hw_reg;
        case ($urandom_range(0, 6))
            0: s = 0;
            1: s = np_e - 1;
            2: s = rf - hw;
            3: s = rf + hw;
            4: s = rf - hw - 1;
            5: s = rf + hw + 1;
            default: s = $urandom_range(0, np_e - 1);
        endcase
        if (s < 0) s = 0;
        if (s > np_e - 1) s = np_e - 1;
        return s;
    endfunction

    // next bin of the current row; a row style is picked at each row start
    function automatic logic [PowW-1:0] next_power();
        int b;
        b = sb.bin_cnt;
        if (b == 0) begin
            if (force_ref >= 0) begin
                row_mode  = (sb.row_cnt == 0) ? ROW_SMALL : ROW_SPIKE;
                spike_bin = (sb.row_cnt == 1) ? force_ref : force_rng;
            end else begin
                row_mode   = t_row_mode'($urandom_range(0, 4));
                flat_level = rand_power();
                spike_bin  = pick_spike();
            end
        end
        case (row_mode)
            ROW_SPIKE:   return (b == spike_bin) ? PowMax : PowW'($urandom_range(0, 1023));
            ROW_FLAT:    return flat_level;
            ROW_SMALL:   return PowW'($urandom_range(0, 15));
            ROW_EXTREME: return $urandom_range(0, 1) ? PowMax : '0;
            default:     return rand_power();
        endcase
    endfunction

    // a num_points write mid-capture must not expose never-written background
    function automatic bit np_fits(logic [CfgDataW-1:0] raw);
        int unsigned n;
        n = raw[NpW-1:0];
        if (n < 2) n = 2;
        if (n > MaxPoints) n = MaxPoints;
        if (sb.row_cnt == 0) return 1'b1;
        for (int i = 0; i < n; i++)
            if (!sb.bg_seen[i]) return 1'b0;
        return 1'b1;
    endfunction

    // ------------------------------------------------------------------------
    // Driver tasks
    // ------------------------------------------------------------------------
    task automatic send_item(input logic [PowW-1:0] pw, input int unsigned gap);
        if (gap != 0) begin
            bins_if.valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        bins_if.valid <= 1'b1;
        bins_if.power <= pw;
        do @(posedge i_clk); while (!bins_if.ready);
        sb.absorb_bin(pw);
    endtask

    // hold the source until every predicted velocity has been seen
    task automatic pause_for_results();
        bins_if.valid <= 1'b0;
        do @(posedge i_clk); while (sb.pending() != 0);
    endtask

    // drained and settled: safe point for register writes
    task automatic wait_idle();
        pause_for_results();
        repeat (SettleCycles) @(posedge i_clk);
    endtask

    task automatic apply_settings(input logic [3:0] mask, input logic [CfgDataW-1:0] np_v,
                                  input logic [CfgDataW-1:0] nrb_v,
                                  input logic [CfgDataW-1:0] hw_v,
                                  input logic [CfgDataW-1:0] step_v);
        logic [CfgDataW-1:0] vals [4];
        dspv_pkg::t_cfg_idx  idxs [4];
        vals = '{np_v, nrb_v, hw_v, step_v};
        idxs = '{dspv_pkg::CFG_NUM_POINTS, dspv_pkg::CFG_NUM_RANGE_BINS,
                 dspv_pkg::CFG_HALF_WINDOW, dspv_pkg::CFG_VELOCITY_STEP};
        for (int i = 0; i < 4; i++) begin
            if (mask[i]) begin
                cfg_we   <= 1'b1;
                cfg_idx  <= idxs[i];
                cfg_data <= vals[i];
                @(posedge i_clk);
                sb.write_cfg(idxs[i], vals[i]);
            end
        end
        cfg_we <= 1'b0;
    endtask

    // ------------------------------------------------------------------------
    // Sink: random back-pressure on the velocity channel
    // ------------------------------------------------------------------------
    initial begin
        int unsigned n;
        forever begin
            n = pick_gap();
            if (n != 0) begin
                vel_if.ready <= 1'b0;
                repeat (n) @(posedge i_clk);
            end
            vel_if.ready <= 1'b1;
            repeat ($urandom_range(1, 20)) @(posedge i_clk);
        end
    end

    // ------------------------------------------------------------------------
    // Monitor: every accepted velocity transaction goes to the scoreboard
    // ------------------------------------------------------------------------
    always @(posedge i_clk) begin
        t_velocity_rec got;
        if (i_rst_n && vel_if.valid && vel_if.ready) begin
            got.velocity    = vel_if.velocity;
            got.range_bin   = vel_if.range_bin;
            got.peak_offset = vel_if.peak_offset;
            got.last_bin    = vel_if.last_bin;
            sb.check_velocity(got);
        end
    end

    // ------------------------------------------------------------------------
    // Watchdog: too long without any transaction ends the run
    // ------------------------------------------------------------------------
    always @(posedge i_clk) begin
        if ((bins_if.valid && bins_if.ready) || (vel_if.valid && vel_if.ready))
            idle_cycles = 0;
        else
            idle_cycles = idle_cycles + 1;
        if (idle_cycles >= WatchdogLimit) begin
            $display("watchdog: no transaction for %0d cycles", idle_cycles);
            $display("== FAIL ==");
            $finish;
        end
    end

    // ------------------------------------------------------------------------
    // Main sequence
    // ------------------------------------------------------------------------
    initial begin
        logic [PowW-1:0]     directed_bins [24];
        logic [CfgDataW-1:0] np_v;
        logic [CfgDataW-1:0] nrb_v;
        logic [CfgDataW-1:0] hw_v;
        logic [CfgDataW-1:0] step_v;
        logic [3:0]          mask;
        int                  rand_items;
        int                  n;

        sb            = new();
        idle_cycles   = 0;
        rand_items    = 0;
        calm          = 1'b0;
        row_mode      = ROW_RANDOM;
        spike_bin     = 0;
        flat_level    = '0;
        i_rst_n       <= 1'b0;
        cfg_we        <= 1'b0;
        cfg_idx       <= dspv_pkg::CFG_NUM_POINTS;
        cfg_data      <= '0;
        bins_if.valid <= 1'b0;
        bins_if.power <= '0;
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // two-bin spectrum, single range row, full window, largest step;
        // num_points and num_range_bins below range saturate to 2 and 1
        apply_settings(4'b1111, 0, 0, 1023, 32'hFFFF_FFFF);
        directed_bins = '{
            // negative reference difference at bin 0, peak at the reference
            PowMax, '0,     '0,     PowMax, '0,     48'd5,
            // tied reference picks bin 0, peak one bin up
            '0,     '0,     48'd7,  48'd7,  48'd3,  48'd9,
            // reference at bin 1, peak one bin down
            PowMax, PowMax, '0,     PowMax, PowMax, '0,
            // tie in the range row: lowest bin wins
            '0,     '0,     '0,     48'd1,  48'd4,  48'd4
        };
        foreach (directed_bins[i]) send_item(directed_bins[i], pick_gap());

        // random phases; registers change between them, captures run on
        while (rand_items < RandomItems) begin
            wait_idle();
            case ($urandom_range(0, 9))
                0: np_v = 0;
                1: np_v = 1;
                2: np_v = 2;
                3: np_v = 3;
                8: np_v = $urandom_range(17, 40);
                9: np_v = $urandom_range(2, 8);
                default: np_v = $urandom_range(4, 16);
            endcase
            case ($urandom_range(0, 9))
                0: nrb_v = 0;
                1: nrb_v = MaxRangeBins;
                2: nrb_v = $urandom_range(65, 127);
                default: nrb_v = $urandom_range(1, 8);
            endcase
            case ($urandom_range(0, 6))
                0: hw_v = 0;
                1: hw_v = 1;
                2: hw_v = 1023;
                3: hw_v = $urandom_range(0, 1023);
                default: hw_v = $urandom_range(0, 12);
            endcase
            case ($urandom_range(0, 5))
                0: step_v = 0;
                1: step_v = 32'hFFFF_FFFF;
                2: step_v = 32'd65536;
                default: step_v = $urandom;
            endcase
            mask = 4'($urandom_range(1, 15));
            if (mask[0] && !np_fits(np_v)) mask[0] = 1'b0;
            apply_settings(mask, np_v, nrb_v, hw_v, step_v);

            calm = ($urandom_range(0, 4) == 0);
            n = $urandom_range(10, 80);
            for (int k = 0; k < n; k++) begin
                send_item(next_power(), pick_gap());
                rand_items++;
                if ($urandom_range(0, 199) == 0) pause_for_results();
            end
            // sometimes end the phase on a row boundary
            if ($urandom_range(0, 1)) begin
                while (sb.bin_cnt != 0) begin
                    send_item(next_power(), pick_gap());
                    rand_items++;
                end
            end
        end

        // close the open capture: the current range row becomes the last
        calm = 1'b0;
        wait_idle();
        apply_settings(4'b0010, 0, 1, 0, 0);
        while (!(sb.row_cnt == 0 && sb.bin_cnt == 0))
            send_item(next_power(), pick_gap());

        // wide spectrum, reference at bin 0 and peak at the top bin
        wait_idle();
        force_ref = 0;
        force_rng = WideNp - 1;
        apply_settings(4'b1111, WideNp, 1, 1023, 32'hFFFF_FFFF);
        repeat (3 * WideNp) send_item(next_power(), pick_gap());

        // wide spectrum, reference at the top bin and peak at bin 0
        wait_idle();
        force_ref = WideNp - 1;
        force_rng = 0;
        apply_settings(4'b0001, WideNp, 0, 0, 0);
        repeat (3 * WideNp) send_item(next_power(), pick_gap());
        force_ref = -1;
        force_rng = -1;

        wait_idle();
        if (sb.pending() != 0)
            $display("%0d predicted velocities never arrived", sb.pending());
        if (sb.errors == 0 && sb.pending() == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

endmodule

[filelist.f]
design/dspv_pkg.sv
design/dspv_in_if.sv
design/dspv_out_if.sv
design/doppler_spectrum_peak_velocity.sv
dv/doppler_spectrum_peak_velocity_tb.sv
